>>> src/tasl_pkg.sv
// ----------------------------------------------------------------------------
// tasl_pkg
// shared constants for the three-axis second-order low-pass filter
// ----------------------------------------------------------------------------
package tasl_pkg;

  // default sample width and coefficient fraction bits
  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned COEF_FRAC_BITS = 16;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B0     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_A1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_A2 = CFG_IDX_W'(2);

endpackage

>>> src/tasl_if.sv
// ----------------------------------------------------------------------------
// tasl interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tasl_in_if #(
  parameter int unsigned W = tasl_pkg::SAMPLE_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_sample;
  logic signed [W-1:0] y_sample;
  logic signed [W-1:0] z_sample;

  modport source (output valid, output x_sample, output y_sample, output z_sample,
                  input ready);
  modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                  output ready);
endinterface

interface tasl_out_if #(
  parameter int unsigned W = tasl_pkg::SAMPLE_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_filtered;
  logic signed [W-1:0] y_filtered;
  logic signed [W-1:0] z_filtered;

  modport source (output valid, output x_filtered, output y_filtered,
                  output z_filtered, input ready);
  modport sink   (input valid, input x_filtered, input y_filtered,
                  input z_filtered, output ready);
endinterface

interface tasl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tasl_pkg::CFG_IDX_W-1:0]      index;
  logic [tasl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/tasl_cfg.sv
// ----------------------------------------------------------------------------
// tasl_cfg
// coefficient register file written through the configuration channel
// ----------------------------------------------------------------------------
module tasl_cfg #(
  parameter int unsigned F = tasl_pkg::COEF_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tasl_cfg_if.sink     cfg_i,
  output logic [F:0]   b0_o,
  output logic [F:0]   a1_o,
  output logic [F:0]   a2_o
);

  logic [F:0] b0_q, a1_q, a2_q;
  logic [F:0] wdata;

  assign cfg_i.ready = 1'b1;
  assign wdata       = cfg_i.data[F:0];  // wide writes keep the low bits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= (F+1)'(1) << F;  // unity gain
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tasl_pkg::CFG_GAIN_B0:     b0_q <= wdata;
        tasl_pkg::CFG_FEEDBACK_A1: a1_q <= wdata;
        tasl_pkg::CFG_FEEDBACK_A2: a2_q <= wdata;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  assign b0_o = b0_q;
  assign a1_o = a1_q;
  assign a2_o = a2_q;

endmodule

>>> src/tasl_lane.sv
// ----------------------------------------------------------------------------
// tasl_lane
// one axis: multiply-accumulate, round, saturate and output history
// ----------------------------------------------------------------------------
module tasl_lane #(
  parameter int unsigned W = tasl_pkg::SAMPLE_WIDTH,
  parameter int unsigned F = tasl_pkg::COEF_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic signed [W-1:0] x_i,
  input  logic        [F:0]   b0_i,
  input  logic        [F:0]   a1_i,
  input  logic        [F:0]   a2_i,
  output logic signed [W-1:0] y_o
);

  // sum of three products stays below 2^(W+F+2) in magnitude
  localparam int unsigned SW = W + F + 3;
  localparam int unsigned RW = SW - F;
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (F - 1));
  localparam logic signed [RW-1:0] MAXV = RW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [RW-1:0] MINV = ~MAXV;

  logic signed [W-1:0]  y1_q, y2_q;
  logic signed [SW-1:0] pb, p1, p2, acc;
  logic signed [RW-1:0] rnd;

  always_comb begin
    pb  = $signed(SW'({1'b0, b0_i})) * SW'(x_i);
    p1  = $signed(SW'({1'b0, a1_i})) * SW'(y1_q);
    p2  = $signed(SW'({1'b0, a2_i})) * SW'(y2_q);
    acc = pb + p1 - p2 + HALF;
    rnd = $signed(acc[SW-1:F]);  // floor after adding one half
    if (rnd > MAXV) begin
      y_o = MAXV[W-1:0];
    end else if (rnd < MINV) begin
      y_o = MINV[W-1:0];
    end else begin
      y_o = rnd[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q <= '0;
      y2_q <= '0;
    end else if (en_i) begin
      y2_q <= y1_q;
      y1_q <= y_o;
    end
  end

endmodule

>>> src/three_axis_second_order_lowpass_core.sv
// ----------------------------------------------------------------------------
// three_axis_second_order_lowpass_core
// second-order recursive low-pass filter over three accelerometer axes
// ----------------------------------------------------------------------------
// Each accepted sample beat yields one result beat once the output is free;
// one beat per cycle is sustained while the output is ready. A sample is
// registered, then, once the result register is empty or being taken, every
// axis computes b0*x + a1*y1 - a2*y2 in one combinational
// multiply-accumulate stage, rounds half up at the binary point, saturates,
// and loads the result register together with the axis history. That single
// stage sets the clock-rate limit. While a finished result waits, input ready
// stays high only until the sample register holds a beat, so at most two
// beats are held inside. Coefficients are written through the configuration
// channel (always ready) and should only change while the filter is idle.
// ----------------------------------------------------------------------------
module three_axis_second_order_lowpass_core #(
  parameter int unsigned SAMPLE_WIDTH   = tasl_pkg::SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = tasl_pkg::COEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tasl_cfg_if.sink    cfg_i,
  tasl_in_if.sink     smp_i,
  tasl_out_if.source  flt_o
);

  localparam int unsigned W = SAMPLE_WIDTH;
  localparam int unsigned F = COEF_FRAC_BITS;

  // coefficients
  logic [F:0] b0, a1, a2;

  // sample register
  logic                in_vld_q;
  logic signed [W-1:0] x_q, y_q, z_q;

  // result register
  logic                out_vld_q, out_vld_d;
  logic signed [W-1:0] xf_q, yf_q, zf_q;
  logic signed [W-1:0] xf_d, yf_d, zf_d;

  logic advance;   // sample register moves into the result register
  logic in_beat;

  tasl_cfg #(.F(F)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .b0_o   (b0),
    .a1_o   (a1),
    .a2_o   (a2)
  );

  // a slot opens when the result register is empty or being taken
  assign advance     = in_vld_q && (!out_vld_q || flt_o.ready);
  assign smp_i.ready = !in_vld_q || advance;
  assign in_beat     = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (smp_i.ready) begin
      in_vld_q <= smp_i.valid;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q <= smp_i.x_sample;
      y_q <= smp_i.y_sample;
      z_q <= smp_i.z_sample;
    end
  end

  // one lane per axis, history advances only when a result is produced
  tasl_lane #(.W(W), .F(F)) u_lane_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(advance), .x_i(x_q),
    .b0_i(b0), .a1_i(a1), .a2_i(a2), .y_o(xf_d)
  );
  tasl_lane #(.W(W), .F(F)) u_lane_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(advance), .x_i(y_q),
    .b0_i(b0), .a1_i(a1), .a2_i(a2), .y_o(yf_d)
  );
  tasl_lane #(.W(W), .F(F)) u_lane_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(advance), .x_i(z_q),
    .b0_i(b0), .a1_i(a1), .a2_i(a2), .y_o(zf_d)
  );

  // result valid: set on advance, cleared when taken with nothing behind it
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (flt_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      xf_q <= xf_d;
      yf_q <= yf_d;
      zf_q <= zf_d;
    end
  end

  assign flt_o.valid      = out_vld_q;
  assign flt_o.x_filtered = xf_q;
  assign flt_o.y_filtered = yf_q;
  assign flt_o.z_filtered = zf_q;

endmodule

>>> src/tasl_checker.sv
// ----------------------------------------------------------------------------
// tasl_checker
// port-level checks on the filter core, attached by bind
// ----------------------------------------------------------------------------
module tasl_checker #(
  parameter int unsigned W = tasl_pkg::SAMPLE_WIDTH
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic [3*W-1:0] out_data_i
);

  logic       in_beat, out_beat;
  logic [1:0] inflight_q, inflight_d;

  assign in_beat    = in_valid_i && in_ready_i;
  assign out_beat   = out_valid_i && out_ready_i;
  assign inflight_d = inflight_q + 2'(in_beat) - 2'(out_beat);

  // beats accepted but not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a held result keeps its payload and its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // with the output empty the sample side must never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a rising result valid traces back to an accepted sample beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching sample beat");

  // a result on offer always has an accepted sample beat behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 2'd0)
    else $error("result repeated");

endmodule

bind three_axis_second_order_lowpass_core tasl_checker #(.W(SAMPLE_WIDTH)) u_tasl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (flt_o.valid),
  .out_ready_i (flt_o.ready),
  .out_data_i  ({flt_o.x_filtered, flt_o.y_filtered, flt_o.z_filtered})
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the three-axis second-order low-pass core against its own
// cycle-free predictor. A short directed run covers pass-through, saturation,
// tie rounding, masked and ignored register writes and saturated history.
// Random runs follow over several coefficient settings. Both the sample side
// and the result side insert random gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SW = tasl_pkg::SAMPLE_WIDTH;
  localparam int unsigned CF = tasl_pkg::COEF_FRAC_BITS;
  localparam int unsigned IW = tasl_pkg::CFG_IDX_W;
  localparam int unsigned DW = tasl_pkg::CFG_DATA_W;

  // register indexes the core does not decode
  localparam logic [IW-1:0] CFG_SPARE_IDX = IW'(3);
  localparam logic [IW-1:0] CFG_TOP_IDX   = {IW{1'b1}};

  // coefficient extremes and unity gain
  localparam logic [CF:0] COEF_MAX  = {(CF+1){1'b1}};
  localparam logic [CF:0] COEF_ZERO = '0;
  localparam logic [CF:0] COEF_ONE  = (CF+1)'(1) << CF;
  localparam logic [CF:0] COEF_HALF = (CF+1)'(1) << (CF-1);

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } axes_t;

  // --------------------------------------------------------------------------
  // scoreboard: holds coefficients and axis history, predicts each result
  // --------------------------------------------------------------------------
  class lowpass_scoreboard;
    logic [CF:0]          gain_b0;
    logic [CF:0]          feedback_a1;
    logic [CF:0]          feedback_a2;
    logic signed [SW-1:0] y_prev  [3];
    logic signed [SW-1:0] y_older [3];
    axes_t                pending_filtered [$];
    int unsigned          mismatches;

    function new();
      gain_b0     = COEF_ONE;
      feedback_a1 = COEF_ZERO;
      feedback_a2 = COEF_ZERO;
      for (int i = 0; i < 3; i++) begin
        y_prev[i]  = '0;
        y_older[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void set_coef(logic [IW-1:0] index, logic [DW-1:0] data);
      case (index)
        tasl_pkg::CFG_GAIN_B0:     gain_b0     = data[CF:0];
        tasl_pkg::CFG_FEEDBACK_A1: feedback_a1 = data[CF:0];
        tasl_pkg::CFG_FEEDBACK_A2: feedback_a2 = data[CF:0];
        default: ;
      endcase
    endfunction

    // one axis: full-width sum, round half up, clamp, shift the history
    function logic signed [SW-1:0] lowpass_axis(int unsigned axis, logic signed [SW-1:0] x);
      longint acc;
      longint rounded;
      longint top;
      longint bottom;
      logic signed [SW-1:0] y;
      top    = (longint'(1) <<< (SW-1)) - 1;
      bottom = -top - 1;
      acc = longint'(gain_b0) * longint'(x)
          + longint'(feedback_a1) * longint'(y_prev[axis])
          - longint'(feedback_a2) * longint'(y_older[axis]);
      rounded = (acc + (longint'(1) <<< (CF-1))) >>> CF;
      if (rounded > top) rounded = top;
      if (rounded < bottom) rounded = bottom;
      y = SW'(rounded);
      y_older[axis] = y_prev[axis];
      y_prev[axis]  = y;
      return y;
    endfunction

    function void note_sample(axes_t s);
      axes_t r;
      r.x = lowpass_axis(0, s.x);
      r.y = lowpass_axis(1, s.y);
      r.z = lowpass_axis(2, s.z);
      pending_filtered.push_back(r);
    endfunction

    function void check_result(axes_t got);
      axes_t want;
      if (pending_filtered.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual x %0d y %0d z %0d",
                 $time, got.x, got.y, got.z);
        mismatches++;
        return;
      end
      want = pending_filtered.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: x_filtered mismatch, expected %0d, actual %0d", $time, want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $display("%0t: y_filtered mismatch, expected %0d, actual %0d", $time, want.y, got.y);
        mismatches++;
      end
      if (got.z !== want.z) begin
        $display("%0t: z_filtered mismatch, expected %0d, actual %0d", $time, want.z, got.z);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_filtered.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and channels
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tasl_cfg_if         cfg_bus ();
  tasl_in_if  #(SW)   smp_bus ();
  tasl_out_if #(SW)   flt_bus ();

  three_axis_second_order_lowpass_core #(
    .SAMPLE_WIDTH   (SW),
    .COEF_FRAC_BITS (CF)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .smp_i  (smp_bus),
    .flt_o  (flt_bus)
  );

  lowpass_scoreboard filter_scoreboard = new();

  // when set, neither side inserts gaps
  bit steady_flow = 1'b0;

  function automatic int unsigned draw_gap();
    if (steady_flow) return 0;
    return $urandom_range(0, 14);
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stall before each beat, check on handshake
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    axes_t got;
    flt_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_gap();
      if (stall != 0) begin
        flt_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      flt_bus.ready = 1'b1;
      @(posedge clk_i);
      while (!flt_bus.valid) @(posedge clk_i);
      got.x = flt_bus.x_filtered;
      got.y = flt_bus.y_filtered;
      got.z = flt_bus.z_filtered;
      filter_scoreboard.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // sample side
  // --------------------------------------------------------------------------

  // valid stays high across back-to-back beats, drops only for a gap
  task automatic send_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                             logic signed [SW-1:0] z);
    int unsigned gap;
    axes_t s;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      smp_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_bus.valid    = 1'b1;
    smp_bus.x_sample = x;
    smp_bus.y_sample = y;
    smp_bus.z_sample = z;
    @(posedge clk_i);
    while (!smp_bus.ready) @(posedge clk_i);
    s.x = x;
    s.y = y;
    s.z = z;
    filter_scoreboard.note_sample(s);
  endtask

  // stop sending and wait until every result is back, plus pipeline slack
  task automatic drain_filter();
    @(negedge clk_i);
    smp_bus.valid = 1'b0;
    while (filter_scoreboard.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register writes only ever happen with the filter drained
  task automatic write_coef(logic [IW-1:0] index, logic [DW-1:0] data);
    drain_filter();
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = index;
    cfg_bus.data  = data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    filter_scoreboard.set_coef(index, data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // sometimes junk in the bits above the coefficient, which must be dropped
  function automatic logic [DW-1:0] coef_word(logic [CF:0] c);
    logic [DW-1:0] d;
    d = '0;
    if ($urandom_range(0, 2) == 0) d = $urandom;
    d[CF:0] = c;
    return d;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SW'($urandom);
      4:       return SW'(int'($urandom_range(0, 512)) - 256);
      default: return SW'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic random_run(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // stretches of full rate now and then
      if (i % 20 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      // occasional mid-run pause until the filter has emptied
      if ($urandom_range(0, 59) == 0) drain_filter();
      send_sample(pick_sample(), pick_sample(), pick_sample());
    end
    steady_flow = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run limit
  // --------------------------------------------------------------------------
  initial begin
    #3000000;
    $display("three_axis_second_order_lowpass_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CF:0] b0;
    logic [CF:0] a1;
    logic [CF:0] a2;
    logic [DW-1:0] junk;

    rst_ni           = 1'b0;
    smp_bus.valid    = 1'b0;
    smp_bus.x_sample = '0;
    smp_bus.y_sample = '0;
    smp_bus.z_sample = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset coefficients: unity gain, no feedback, so samples pass straight
    send_sample(SMP_MAX, SMP_MIN, SW'(0));
    send_sample(SMP_MIN, SMP_MAX, SW'(-1));
    send_sample(SW'(1), SW'(-1), SW'(16'h5555));
    send_sample(SW'(16'hAAAA), SW'(16'h5555), SW'(16'hAAAA));
    send_sample(SW'(0), SW'(0), SW'(0));

    // largest gain drives both rails
    write_coef(tasl_pkg::CFG_GAIN_B0, DW'(COEF_MAX));
    send_sample(SMP_MAX, SMP_MIN, SW'(1));
    send_sample(SW'(-1), SW'(2), SW'(-2));

    // half gain: odd inputs land exactly on a half, ties go towards plus
    write_coef(tasl_pkg::CFG_GAIN_B0, DW'(COEF_HALF));
    send_sample(SW'(1), SW'(-1), SW'(3));
    send_sample(SW'(-3), SW'(5), SW'(-5));
    send_sample(SMP_MIN, SMP_MAX, SW'(-32767));

    // unity gain written with junk above bit 16, then writes to undecoded
    // indexes that must leave everything alone
    junk = $urandom;
    junk[CF:0] = COEF_ONE;
    junk[DW-1] = 1'b1;
    write_coef(tasl_pkg::CFG_GAIN_B0, junk);
    write_coef(CFG_SPARE_IDX, DW'(COEF_MAX));
    write_coef(CFG_TOP_IDX, '0);
    send_sample(SW'(1000), SW'(-1000), SW'(12345));

    // full feedback both ways: saturated values are fed back as history
    write_coef(tasl_pkg::CFG_FEEDBACK_A1, {{(DW-CF-1){1'b1}}, COEF_MAX});
    write_coef(tasl_pkg::CFG_FEEDBACK_A2, DW'(COEF_MAX));
    send_sample(SMP_MAX, SMP_MIN, SW'(20000));
    send_sample(SMP_MAX, SMP_MIN, SW'(20000));
    send_sample(SMP_MAX, SMP_MIN, SW'(-20000));
    send_sample(SW'(0), SW'(0), SW'(0));
    send_sample(SW'(0), SW'(0), SW'(0));
    send_sample(SW'(0), SW'(0), SW'(0));

    // random runs, one coefficient setting each
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          b0 = (CF+1)'($urandom);
          a1 = COEF_ZERO;
          a2 = COEF_ZERO;
        end
        1: begin
          b0 = COEF_MAX;
          a1 = COEF_MAX;
          a2 = COEF_MAX;
        end
        2: begin
          b0 = COEF_ZERO;
          a1 = COEF_ZERO;
          a2 = COEF_ZERO;
        end
        3: begin
          b0 = COEF_MAX;
          a1 = COEF_ZERO;
          a2 = COEF_MAX;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            // a realistic stable low-pass
            a1 = (CF+1)'($urandom_range(98304, 127000));
            a2 = a1 - COEF_ONE + (CF+1)'($urandom_range(256, 4096));
            b0 = (CF+1)'($urandom_range(64, 16384));
          end else begin
            b0 = (CF+1)'($urandom);
            a1 = (CF+1)'($urandom);
            a2 = (CF+1)'($urandom);
          end
        end
      endcase
      write_coef(tasl_pkg::CFG_GAIN_B0, coef_word(b0));
      write_coef(tasl_pkg::CFG_FEEDBACK_A1, coef_word(a1));
      write_coef(tasl_pkg::CFG_FEEDBACK_A2, coef_word(a2));
      random_run(80);
    end

    // wind down: everything back, then a few idle cycles for strays
    @(negedge clk_i);
    smp_bus.valid = 1'b0;
    while (filter_scoreboard.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (filter_scoreboard.mismatches == 0 && filter_scoreboard.outstanding() == 0) begin
      $display("three_axis_second_order_lowpass_core test passed");
    end else begin
      $display("three_axis_second_order_lowpass_core test failed");
    end
    $finish;
  end

endmodule
